/* rtl/core/scvs_pkg.sv */
// Shared types and constants for the scaled count vector similarity unit.
`timescale 1ns / 1ps
package scvs_pkg;

	localparam int CNT_W   = 16;
	localparam int SCORE_W = 17;
	localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

	// Classified element word passed from the front to the back
	typedef struct packed {
		logic               cmp;       // pair is compared (either count nonzero)
		logic               need_div;  // score needs d * 2^24 / s
		logic               last;
		logic [SCORE_W-1:0] dscore;    // score when no division is needed
		logic [7:0]         dlow;      // difference, known below 256 when dividing
		logic [CNT_W-1:0]   dev;
	} entry_t;

endpackage

/* rtl/core/scvs_front.sv */
// Front end: takes input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module scvs_front import scvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [CNT_W-1:0] count_first,
	input  logic [CNT_W-1:0] count_second,
	input  logic [CNT_W-1:0] deviation_q8_8,
	input  logic             last_element,
	input  logic             cfg_write,
	input  logic             cfg_data,
	input  logic             deq,
	output logic             qempty,
	output entry_t           head
);

	logic             scale_q;
	logic [CNT_W-1:0] diff;
	logic             big;
	entry_t           ent;
	entry_t           mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             enq;

	// Scaling register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_q <= 1'b1;
		else if (cfg_write) scale_q <= cfg_data;
	end

	// Classify: a distance of one or more (d*256 >= s) scores zero
	always_comb begin
		diff = (count_first >= count_second) ? count_first - count_second
		                                     : count_second - count_first;
		big  = (diff[CNT_W-1:8] != '0) || ({diff[7:0], 8'h00} >= deviation_q8_8);
		ent.cmp      = (count_first != '0) || (count_second != '0);
		ent.last     = last_element;
		ent.dlow     = diff[7:0];
		ent.dev      = deviation_q8_8;
		ent.need_div = 1'b0;
		if (diff == '0) begin
			ent.dscore = SCORE_ONE;
		end else if (scale_q && deviation_q8_8 != '0 && !big) begin
			ent.dscore   = '0;
			ent.need_div = 1'b1;
		end else begin
			ent.dscore = '0;
		end
	end

	assign full   = cnt_q[1];
	assign qempty = (cnt_q == 2'd0);
	assign enq    = push && !full;
	assign head   = mem_q[rp_q];

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (enq) mem_q[wp_q] <= ent;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

/* rtl/core/scvs_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module scvs_div #(
	parameter int SW  = 28,
	parameter int VW  = 16,
	parameter int STW = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [VW-1:0]  ld_rem,
	input  logic [SW-1:0]  ld_num,
	input  logic [STW-1:0] ld_steps,
	input  logic [VW-1:0]  divisor,
	output logic           done,
	output logic [SW-1:0]  quo
);

	logic [VW-1:0]  rem_q;
	logic [SW-1:0]  num_q, quo_q;
	logic [STW-1:0] cnt_q;
	logic           busy_q, done_q;
	logic [VW:0]    trial;
	logic           ge;
	logic [VW-1:0]  rem_n;

	// One subtract-and-compare step
	always_comb begin
		trial = {rem_q, num_q[SW-1]};
		ge    = trial >= {1'b0, divisor};
		rem_n = ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ld_rem;
			num_q <= ld_num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			num_q <= num_q << 1;
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ld_steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STW'(1);
			if (cnt_q == STW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/scvs_back.sv */
// Back end: scores elements, keeps the sums and produces the mean result word.
`timescale 1ns / 1ps
module scvs_back import scvs_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int CW  = 11,
	parameter int SW  = 28,
	parameter int VW  = 16,
	parameter int STW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               qempty,
	input  entry_t             head,
	output logic               deq,
	output logic               empty,
	input  logic               pop,
	output logic [SCORE_W-1:0] similarity_q0_16,
	output logic [CW-1:0]      compared_count
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EDIV = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_FDIV = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]         state_q;
	entry_t             ent_q;
	logic [SW-1:0]      sum_q;
	logic [CW-1:0]      pair_q;
	logic [SCORE_W-1:0] res_q;
	logic               out_v_q;
	logic [SCORE_W-1:0] out_sim_q;
	logic [CW-1:0]      out_cnt_q;
	logic               room;
	logic               out_free;
	logic               dstart;
	logic [VW-1:0]      ld_rem, divisor;
	logic [SW-1:0]      ld_num;
	logic [STW-1:0]     ld_steps;
	logic               ddone;
	logic [SW-1:0]      quo;

	assign room     = pair_q < CW'(MAX_ELEMENTS);
	assign out_free = !out_v_q || pop;
	assign deq      = (state_q == ST_IDLE) && !qempty;

	// Divider load: element division in IDLE, final mean in LAST
	always_comb begin
		dstart   = 1'b0;
		ld_rem   = VW'({head.dlow, 8'h00});
		ld_num   = '0;
		ld_steps = STW'(16);
		if (state_q == ST_IDLE && !qempty && head.cmp && room && head.need_div)
			dstart = 1'b1;
		if (state_q == ST_LAST && ent_q.last && pair_q != '0) begin
			dstart   = 1'b1;
			ld_rem   = '0;
			ld_num   = sum_q;
			ld_steps = STW'(SW);
		end
		divisor = (state_q == ST_FDIV || state_q == ST_LAST) ? VW'(pair_q) : VW'(ent_q.dev);
	end

	scvs_div #(.SW(SW), .VW(VW), .STW(STW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart),
		.ld_rem   (ld_rem),
		.ld_num   (ld_num),
		.ld_steps (ld_steps),
		.divisor  (divisor),
		.done     (ddone),
		.quo      (quo)
	);

	always_ff @(posedge clk) begin
		if (deq) ent_q <= head;
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (state_q == ST_OUT && out_free) out_v_q <= 1'b1;
		else if (pop) out_v_q <= 1'b0;
	end

	// Sequencer, sums and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			pair_q    <= '0;
			res_q     <= '0;
			out_sim_q <= '0;
			out_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!qempty) begin
						if (head.cmp && room && head.need_div) begin
							state_q <= ST_EDIV;
						end else begin
							state_q <= ST_LAST;
							if (head.cmp && room) begin
								sum_q  <= sum_q + SW'(head.dscore);
								pair_q <= pair_q + CW'(1);
							end
						end
					end
				end
				ST_EDIV: begin
					if (ddone) begin
						sum_q   <= sum_q + SW'(SCORE_ONE - {1'b0, quo[15:0]});
						pair_q  <= pair_q + CW'(1);
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (!ent_q.last) begin
						state_q <= ST_IDLE;
					end else if (pair_q == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (ddone) begin
						res_q   <= quo[SCORE_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_sim_q <= res_q;
						out_cnt_q <= pair_q;
						sum_q     <= '0;
						pair_q    <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty            = !out_v_q;
	assign similarity_q0_16 = out_sim_q;
	assign compared_count   = out_cnt_q;

endmodule

/* rtl/core/scaled_count_vector_similarity_unit.sv */
// Top level of the scaled count vector similarity unit.
//
//  channel   handshake        word
//  input     push / full      count_first, count_second, deviation_q8_8, last_element
//  result    pop / empty      similarity_q0_16, compared_count
//  config    cfg_write        cfg_data (deviation scaling enable)
//
// An element that needs a scaled division runs through EDIV in the back end,
// on the 16-step shared divider; other elements go from IDLE straight to LAST.
// A last element adds the mean division of CW+17 steps on the same divider.
// Reset clears the sums, the queue and the result register; scaling resets to on.
// A two-word queue lets input words land while the back end divides or a result waits.
`timescale 1ns / 1ps
module scaled_count_vector_similarity_unit import scvs_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [CNT_W-1:0]                    count_first,
	input  logic [CNT_W-1:0]                    count_second,
	input  logic [CNT_W-1:0]                    deviation_q8_8,
	input  logic                                last_element,
	output logic                                empty,
	input  logic                                pop,
	output logic [SCORE_W-1:0]                  similarity_q0_16,
	output logic [$clog2(MAX_ELEMENTS + 1)-1:0] compared_count,
	input  logic                                cfg_write,
	input  logic                                cfg_data
);

	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int SW  = CW + SCORE_W;
	localparam int VW  = (CW > CNT_W) ? CW : CNT_W;
	localparam int STW = $clog2(SW + 1);

	logic   deq;
	logic   qempty;
	entry_t head;

	scvs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.count_first    (count_first),
		.count_second   (count_second),
		.deviation_q8_8 (deviation_q8_8),
		.last_element   (last_element),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.deq            (deq),
		.qempty         (qempty),
		.head           (head)
	);

	scvs_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.CW           (CW),
		.SW           (SW),
		.VW           (VW),
		.STW          (STW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.qempty           (qempty),
		.head             (head),
		.deq              (deq),
		.empty            (empty),
		.pop              (pop),
		.similarity_q0_16 (similarity_q0_16),
		.compared_count   (compared_count)
	);

endmodule

/* tb/sv/tb_scaled_count_vector_similarity_unit.sv */
// Testbench for the scaled count vector similarity unit: directed table, random vectors, predictor.
`timescale 1ns / 1ps
module tb_scaled_count_vector_similarity_unit;
	import scvs_pkg::*;

	localparam int MAXE = 1024;
	localparam int CWT = 11;
	localparam int WD_LIMIT = 20000;

	// Directed stimulus row; exp_valid marks a typed-in result
	typedef struct {
		logic [CNT_W-1:0]   a;
		logic [CNT_W-1:0]   b;
		logic [CNT_W-1:0]   s;
		logic               last;
		logic               exp_valid;
		logic [SCORE_W-1:0] exp_sim;
		logic [CWT-1:0]     exp_cnt;
	} row_t;

	typedef struct {
		logic [SCORE_W-1:0] sim;
		logic [CWT-1:0]     cnt;
	} mean_t;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [CNT_W-1:0] count_first = 0;
	logic [CNT_W-1:0] count_second = 0;
	logic [CNT_W-1:0] deviation_q8_8 = 0;
	logic last_element = 0;
	logic empty;
	logic pop = 0;
	logic [SCORE_W-1:0] similarity_q0_16;
	logic [CWT-1:0] compared_count;
	logic cfg_write = 0;
	logic cfg_data = 0;

	scaled_count_vector_similarity_unit #(.MAX_ELEMENTS(MAXE)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.count_first(count_first), .count_second(count_second),
		.deviation_q8_8(deviation_q8_8), .last_element(last_element),
		.empty(empty), .pop(pop), .similarity_q0_16(similarity_q0_16),
		.compared_count(compared_count), .cfg_write(cfg_write), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Predictor state
	logic        scale_on;
	logic [26:0] sum_acc;
	logic [10:0] pairs_acc;
	mean_t       mean_q[$];
	int          errors = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          watchdog = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic [SCORE_W-1:0] pair_score(logic [15:0] a, logic [15:0] b,
			logic [15:0] s);
		logic [63:0] d;
		logic [63:0] q;
		d = (a >= b) ? 64'(a - b) : 64'(b - a);
		if (scale_on && s != 0) q = (d << 24) / s;
		else q = d << 16;
		return (q >= 64'd65536) ? '0 : SCORE_W'(64'd65536 - q);
	endfunction

	// Update sums; returns 1 and the mean when a word closes a vector pair
	function automatic bit predict_mean(logic [15:0] a, logic [15:0] b, logic [15:0] s,
			logic last, output mean_t m);
		if ((a != 0 || b != 0) && pairs_acc < MAXE) begin
			sum_acc += 27'(pair_score(a, b, s));
			pairs_acc++;
		end
		if (!last) return 0;
		m.sim = (pairs_acc != 0) ? SCORE_W'(sum_acc / pairs_acc) : '0;
		m.cnt = pairs_acc;
		sum_acc = 0;
		pairs_acc = 0;
		return 1;
	endfunction

	// Result side: random stall, compare against oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (mean_q.size() == 0) report("result with nothing expected");
			else begin
				mean_t m;
				m = mean_q.pop_front();
				if (similarity_q0_16 !== m.sim)
					report($sformatf("similarity %0d exp %0d", similarity_q0_16, m.sim));
				if (compared_count !== m.cnt)
					report($sformatf("count %0d exp %0d", compared_count, m.cnt));
			end
		end
		pop <= ($urandom_range(99) >= recv_stall);
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Push stays high after an accepted word; idling or draining drops it
	task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] s, logic last);
		mean_t m;
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		count_first <= a;
		count_second <= b;
		deviation_q8_8 <= s;
		last_element <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		if (predict_mean(a, b, s, last, m)) mean_q.insert(mean_q.size(), m);
	endtask

	task automatic drain();
		push <= 0;
		while (mean_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_scaling(logic v);
		drain();
		cfg_write <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 0;
		scale_on = v;
	endtask

	// One vector pair of random length and content
	task automatic send_vector(int len);
		logic [15:0] a, b, s;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(5))
				0: begin a = 0; b = 0; end
				1: begin a = 16'($urandom); b = a; end
				2: begin a = 16'($urandom); b = 16'($urandom); end
				default: begin
					a = 16'($urandom_range(300));
					b = 16'(int'(a) + int'($urandom_range(40)) - 20);
				end
			endcase
			s = ($urandom_range(7) == 0) ? 16'($urandom) :
				(($urandom_range(9) == 0) ? 16'h0 : 16'($urandom_range(8000)));
			send_word(a, b, s, i == len - 1);
		end
	endtask

	row_t dir_rows[$];

	initial begin
		mean_t m;
		scale_on = 1;
		sum_acc = 0;
		pairs_acc = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty vector, extremes, equal counts, zero deviation
		dir_rows = '{
			'{0, 0, 0, 1, 1, 17'h0, 11'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, SCORE_ONE, 11'd1},
			'{16'hFFFF, 0, 16'hFFFF, 1, 1, 17'h0, 11'd1},
			'{5, 5, 0, 0, 0, 0, 0},
			'{7, 3, 0, 0, 0, 0, 0},
			'{0, 0, 16'h0100, 1, 1, 17'h8000, 11'd2},
			'{1, 2, 16'h0200, 0, 0, 0, 0},
			'{100, 0, 16'h0001, 0, 0, 0, 0},
			'{0, 1, 16'hFFFF, 0, 0, 0, 0},
			'{3, 4, 16'h0100, 1, 0, 0, 0},
			'{16'hAAAA, 16'h5555, 16'h5555, 1, 0, 0, 0}
		};
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].a, dir_rows[i].b, dir_rows[i].s, dir_rows[i].last);
			if (dir_rows[i].exp_valid) begin
				m = mean_q[$];
				if (m.sim !== dir_rows[i].exp_sim || m.cnt !== dir_rows[i].exp_cnt)
					report($sformatf("row %0d predictor disagrees with table", i));
			end
		end

		// Unscaled mode, then back
		set_scaling(0);
		send_word(9, 9, 16'h0100, 0);
		send_word(9, 8, 16'h0100, 0);
		send_word(0, 16'hFFFF, 16'h0000, 1);
		set_scaling(1);

		// Overflow of pair count: 1030 pairs with nonzero counts, no idling
		for (int i = 0; i < 1030; i++)
			send_word(16'($urandom_range(50) + 1), 16'($urandom_range(50) + 1),
				16'($urandom), i == 1029);

		// Random phases: idle/stall settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 54; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 54; end
				default: begin send_idle = 31; recv_stall = 31; end
			endcase
			if (ph == 4) set_scaling(0);
			if (ph == 6) set_scaling(1);
			for (int v = 0; v < 2; v++) send_vector($urandom_range(1, 16));
			if (ph == 2) drain();
		end

		drain();
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

/* files.f */
rtl/core/scvs_pkg.sv
rtl/core/scvs_front.sv
rtl/core/scvs_div.sv
rtl/core/scvs_back.sv
rtl/core/scaled_count_vector_similarity_unit.sv
tb/sv/tb_scaled_count_vector_similarity_unit.sv
